>>> hdl/stw_pkg.sv
package stw_pkg;

  localparam int TPQ = 960;

  // Position fields are fixed at 16 bits unsigned; the doubled position fits 16 bits.
  localparam int XW = 16;

  // Reciprocal of TPQ at XW fraction bits; the estimate is at most one low.
  localparam int RECIP = (2 ** XW) / TPQ;
  localparam int RCW = $clog2(RECIP + 1);

  localparam int QW = $clog2((2 ** XW - 1) / TPQ + 1);
  localparam int TW = $clog2(TPQ + 1);
  localparam int RW = (TPQ > 1) ? $clog2(TPQ) : 1;

  // Positions in 1/24 tick: 24 * 32767 fits 20 bits.
  localparam int R24W = 20;
  localparam int U24F = 24 * TPQ;
  localparam int U24H = 12 * TPQ;
  localparam int UW = $clog2(U24F + 1);
  localparam int GW = $clog2(12 * TPQ + 1);

  // Sixth-tick value and its split into whole ticks and sixths.
  localparam int SW = R24W - 2;
  localparam int R6SH = 21;
  localparam int RECIP6 = (2 ** R6SH) / 6;
  localparam int R6W = $clog2(RECIP6 + 1);
  localparam int WQW = 16;

  typedef enum logic [2:0] {
    FEEL_NONE     = 3'd0,
    FEEL_TRIP8    = 3'd1,
    FEEL_TRIP16   = 3'd2,
    FEEL_DOT8     = 3'd3,
    FEEL_DOT16    = 3'd4,
    FEEL_SNAP8    = 3'd5,
    FEEL_SNAP16   = 3'd6,
    FEEL_NONE_ALT = 3'd7
  } stw_feel_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic               bypass;
    logic               half;
    logic [3:0]         sn;
    logic [XW-1:0]      x;
    logic [XW-1:0]      mbar;
  } stw_dec_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic               bypass;
    logic               half;
    logic [3:0]         sn;
    logic [QW-1:0]      q;
    logic [RW-1:0]      rem;
  } stw_quo_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic               bypass;
    logic [R24W-1:0]    r24;
  } stw_pos_t;

  // First-half share of a pair in twelfths.
  function automatic logic [3:0] share_of(stw_feel_t feel);
    logic [3:0] sn;
    case (feel)
      FEEL_TRIP8, FEEL_TRIP16: sn = 4'd8;
      FEEL_DOT8, FEEL_DOT16:   sn = 4'd9;
      FEEL_SNAP8, FEEL_SNAP16: sn = 4'd3;
      default:                 sn = 4'd6;
    endcase
    return sn;
  endfunction

  // Sixteenth-level feels use a pair of one eighth note.
  function automatic logic is_half(stw_feel_t feel);
    return feel inside {FEEL_TRIP16, FEEL_DOT16, FEEL_SNAP16};
  endfunction

endpackage

>>> hdl/stw_div.sv
module stw_div
  import stw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  input  stw_dec_t in_data,
  output logic     in_rdy,
  output logic     out_vld,
  output stw_quo_t out_data,
  input  logic     out_rdy
);

  localparam logic [XW:0] TPQ1 = (XW + 1)'(TPQ);
  localparam logic [XW:0] TPQ2 = (XW + 1)'(2 * TPQ);
  localparam logic [XW-1:0] TPQX = XW'(TPQ);

  logic               b_vld_r, c_vld_r, d_vld_r;
  logic               adv_b, adv_c, adv_d;

  stw_dec_t           b_dec_r;
  logic [XW+RCW-1:0]  b_p_r, b_p_nxt;

  stw_dec_t           c_dec_r;
  logic [QW-1:0]      c_qa_r, c_qa_nxt;
  logic [XW-1:0]      c_qt_r, c_qt_nxt;

  stw_quo_t           d_r, d_nxt;
  logic [XW-1:0]      rem0;
  logic               corr;
  logic [XW:0]        lim;

  assign adv_d = !d_vld_r || out_rdy;
  assign adv_c = !c_vld_r || adv_d;
  assign adv_b = !b_vld_r || adv_c;
  assign in_rdy = adv_b;

  // Estimate the quotient by the reciprocal.
  assign b_p_nxt = in_data.x * RCW'(RECIP);

  assign c_qa_nxt = b_p_r[XW +: QW];

  assign c_qt_nxt = XW'(c_qa_nxt) * XW'(TPQ);

  // Correct the estimate once, then check that the pair closes inside the bar.
  always_comb begin
    rem0 = c_dec_r.x - c_qt_r;
    corr = (rem0 >= TPQX);
    lim  = {1'b0, c_qt_r} + (corr ? TPQ2 : TPQ1);
    d_nxt.w      = c_dec_r.w;
    d_nxt.half   = c_dec_r.half;
    d_nxt.sn     = c_dec_r.sn;
    d_nxt.q      = c_qa_r + QW'(corr);
    d_nxt.rem    = corr ? RW'(rem0 - TPQX) : RW'(rem0);
    d_nxt.bypass = c_dec_r.bypass || ({1'b0, c_dec_r.mbar} < lim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      if (adv_b) b_vld_r <= in_vld;
      if (adv_c) c_vld_r <= b_vld_r;
      if (adv_d) d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b && in_vld) begin
      b_dec_r <= in_data;
      b_p_r   <= b_p_nxt;
    end
    if (adv_c && b_vld_r) begin
      c_dec_r <= b_dec_r;
      c_qa_r  <= c_qa_nxt;
      c_qt_r  <= c_qt_nxt;
    end
    if (adv_d && c_vld_r) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld  = d_vld_r;
  assign out_data = d_r;

endmodule

>>> hdl/stw_warp.sv
module stw_warp
  import stw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  input  stw_quo_t in_data,
  output logic     in_rdy,
  output logic     out_vld,
  output stw_pos_t out_data,
  input  logic     out_rdy
);

  localparam logic [RW:0] TPQR = (RW + 1)'(TPQ);

  logic              e_vld_r, f_vld_r;
  logic              adv_e, adv_f;

  logic signed [15:0] e_w_r;
  logic              e_bypass_r, e_half_r;
  logic [R24W-1:0]   e_begin_r, e_begin_nxt;
  logic [GW-1:0]     e_g_r, e_g_nxt;

  stw_pos_t          f_r, f_nxt;

  logic [UW-1:0]     unit24;
  logic [QW+UW-1:0]  begin_full;
  logic [RW:0]       rem2, offs;
  logic              second;
  logic [3:0]        k;
  logic [RW+4:0]     dk;
  logic [GW-1:0]     base;

  assign adv_f  = !f_vld_r || out_rdy;
  assign adv_e  = !e_vld_r || adv_f;
  assign in_rdy = adv_e;

  // Pair start, and the offset moved by the share of the half it lies in.
  always_comb begin
    unit24      = in_data.half ? UW'(U24H) : UW'(U24F);
    begin_full  = in_data.q * unit24;
    e_begin_nxt = begin_full[R24W-1:0];
    rem2        = {in_data.rem, 1'b0};
    second      = (rem2 >= TPQR);
    offs        = second ? (rem2 - TPQR) : rem2;
    k           = second ? (4'd12 - in_data.sn) : in_data.sn;
    dk          = offs * k;
    base        = second ? GW'(TPQ * int'(in_data.sn)) : '0;
    e_g_nxt     = base + GW'(dk);
  end

  always_comb begin
    f_nxt.w      = e_w_r;
    f_nxt.bypass = e_bypass_r;
    f_nxt.r24    = e_begin_r + (e_half_r ? R24W'(e_g_r) : R24W'({e_g_r, 1'b0}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
    end else begin
      if (adv_e) e_vld_r <= in_vld;
      if (adv_f) f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_e && in_vld) begin
      e_w_r      <= in_data.w;
      e_bypass_r <= in_data.bypass;
      e_half_r   <= in_data.half;
      e_begin_r  <= e_begin_nxt;
      e_g_r      <= e_g_nxt;
    end
    if (adv_f && e_vld_r) begin
      f_r <= f_nxt;
    end
  end

  assign out_vld  = f_vld_r;
  assign out_data = f_r;

endmodule

>>> hdl/stw_split.sv
module stw_split
  import stw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  stw_pos_t           in_data,
  output logic               in_rdy,
  output logic               out_vld,
  output logic signed [15:0] out_played_pos,
  output logic [2:0]         out_frac_sixths,
  input  logic               out_rdy
);

  logic               g_vld_r, h_vld_r;
  logic               adv_g, adv_h;

  logic signed [15:0] g_w_r;
  logic               g_bypass_r;
  logic [SW-1:0]      g_s_r, g_s_nxt;
  logic [SW+R6W-1:0]  g_p_r, g_p_nxt;

  logic signed [15:0] h_pos_r, h_pos_nxt;
  logic [2:0]         h_frac_r, h_frac_nxt;

  logic [WQW-1:0]     wh0, whole;
  logic [SW-1:0]      mul6, fr0;
  logic               corr;

  assign adv_h  = !h_vld_r || out_rdy;
  assign adv_g  = !g_vld_r || adv_h;
  assign in_rdy = adv_g;

  // Drop the 1/24-tick bits below a sixth, then divide by six.
  assign g_s_nxt = in_data.r24[R24W-1:2];
  assign g_p_nxt = g_s_nxt * R6W'(RECIP6);

  always_comb begin
    wh0   = g_p_r[R6SH +: WQW];
    mul6  = SW'({wh0, 2'b00}) + SW'({wh0, 1'b0});
    fr0   = g_s_r - mul6;
    corr  = (fr0[3:0] >= 4'd6);
    whole = wh0 + WQW'(corr);
    h_frac_nxt = g_bypass_r ? 3'd0 : (corr ? 3'(fr0[3:0] - 4'd6) : fr0[2:0]);
    h_pos_nxt  = g_bypass_r ? g_w_r : signed'(whole);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
    end else begin
      if (adv_g) g_vld_r <= in_vld;
      if (adv_h) h_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_g && in_vld) begin
      g_w_r      <= in_data.w;
      g_bypass_r <= in_data.bypass;
      g_s_r      <= g_s_nxt;
      g_p_r      <= g_p_nxt;
    end
    if (adv_h && g_vld_r) begin
      h_pos_r  <= h_pos_nxt;
      h_frac_r <= h_frac_nxt;
    end
  end

  assign out_vld         = h_vld_r;
  assign out_played_pos  = h_pos_r;
  assign out_frac_sixths = h_frac_r;

endmodule

>>> hdl/swing_time_warp_top.sv
// Channel   Direction  Beat fields                          Handshake
// in_       input      written_pos s16, feel_code u3,       in_valid / in_stall
//                      bar_len u15
// out_      output     played_pos s16, frac_sixths u3       out_valid / out_stall
//
// One beat enters per cycle while out_stall is low; each beat passes through
// eight register stages (decode, three for the divide by the quarter length,
// two for the warp, two for the split into sixths).
// Reset clears the stage valid bits only.
// out_stall holds the output beat; bubbles inside the pipeline still close up,
// so in_stall rises only when every stage holds a beat.
module swing_time_warp_top
  import stw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_written_pos,
  input  logic [2:0]         in_feel_code,
  input  logic [14:0]        in_bar_len,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_played_pos,
  output logic [2:0]         out_frac_sixths
);

  // Decode stage.
  logic      a_vld_r;
  stw_dec_t  a_r, a_nxt;
  logic      adv_a;
  stw_feel_t feel;

  // Stage boundaries between the units.
  logic      div_rdy;
  logic      quo_vld, quo_rdy;
  stw_quo_t  quo;
  logic      pos_vld, pos_rdy;
  stw_pos_t  pos;

  assign adv_a    = !a_vld_r || div_rdy;
  assign in_stall = !adv_a;

  // Decode the feel. Pass the position through unchanged for no swing or a
  // negative position; the bar check joins that flag after the divide.
  always_comb begin
    feel         = stw_feel_t'(in_feel_code);
    a_nxt.w      = in_written_pos;
    a_nxt.bypass = (feel inside {FEEL_NONE, FEEL_NONE_ALT}) || in_written_pos[15];
    a_nxt.half   = is_half(feel);
    a_nxt.sn     = share_of(feel);
    // Count in pair units: doubling the position and bar halves the unit.
    a_nxt.x      = a_nxt.half ? {in_written_pos[14:0], 1'b0}
                              : {1'b0, in_written_pos[14:0]};
    a_nxt.mbar   = a_nxt.half ? {in_bar_len, 1'b0} : {1'b0, in_bar_len};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv_a) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && in_valid) begin
      a_r <= a_nxt;
    end
  end

  // Pair index and offset into the pair.
  stw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (a_vld_r),
    .in_data  (a_r),
    .in_rdy   (div_rdy),
    .out_vld  (quo_vld),
    .out_data (quo),
    .out_rdy  (quo_rdy)
  );

  // Stretch the offset onto the share, in 1/24 tick.
  stw_warp u_warp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (quo_vld),
    .in_data  (quo),
    .in_rdy   (quo_rdy),
    .out_vld  (pos_vld),
    .out_data (pos),
    .out_rdy  (pos_rdy)
  );

  // Whole ticks and sixths; the last stage is the output register.
  stw_split u_split (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_vld          (pos_vld),
    .in_data         (pos),
    .in_rdy          (pos_rdy),
    .out_vld         (out_valid),
    .out_played_pos  (out_played_pos),
    .out_frac_sixths (out_frac_sixths),
    .out_rdy         (!out_stall)
  );

  // With the output free to move, every stage can advance.
  a_ready_when_out_free: assert property (
    @(posedge clk) disable iff (!rst_n) (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while the output can advance");

  // The corrected remainder stays inside one pair unit.
  a_rem_in_unit: assert property (
    @(posedge clk) disable iff (!rst_n) (quo_vld && !quo.bypass) |-> (quo.rem < RW'(TPQ)))
    else $error("pair remainder out of range");

  // A swung beat always carries a non-negative written position.
  a_swing_nonneg: assert property (
    @(posedge clk) disable iff (!rst_n) (pos_vld && !pos.bypass) |-> !pos.w[15])
    else $error("swung beat carries a negative position");

  a_frac_range: assert property (
    @(posedge clk) disable iff (!rst_n) out_valid |-> (out_frac_sixths <= 3'd5))
    else $error("sixths remainder out of range");

endmodule
